// ===== rtl/tdwc_pkg.sv =====
// Shared types and constants for the trie dictionary word counter.
// Used by the controller, the datapath and the top level.
`default_nettype none

package tdwc_pkg;

	localparam int ACTION_W = 2;
	localparam int NODE_W = 12;
	localparam int LETTER_W = 5;
	localparam int COUNT_W = 32;
	localparam int ALPHA_SIZE = 26;
	localparam int NODE_LIMIT = 1 << NODE_W;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LINK = 2'd0,
		ACT_MARK = 2'd1,
		ACT_TEXT = 2'd2
	} action_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic issue;
		logic commit;
		logic finish;
	} tdwc_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic issue_last;
		logic text_last;
	} tdwc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/trie_dictionary_word_counter_unit.sv =====
// Trie dictionary word counter: counts every occurrence, overlaps included, of
// dictionary words in an A-Z text. After reset the block runs a clearing pass over
// the child table of min(NODE_COUNT, 4096) * 26 entries (106496 at the defaults),
// one entry a cycle, and accepts no item until it ends. Link and mark items leave
// the block idle, ready for the next item. A text letter walks the N active trie
// positions (at most MAX_WORD_LEN + 1): the single read port of the child table
// serves one position a cycle, followed by the flag lookup drain states DRAIN1
// and DRAIN2 and a commit. A result waiting at the output does not hold off new
// items; only the final letter of a text waits for it to be taken.
`default_nettype none

module trie_dictionary_word_counter_unit
	import tdwc_pkg::*;
#(
	parameter int NODE_COUNT = 4096,
	parameter int MAX_WORD_LEN = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [NODE_W-1:0]   node_index,
	input  wire logic [LETTER_W-1:0] letter,
	input  wire logic [NODE_W-1:0]   child_index,
	input  wire logic                last_letter,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [COUNT_W-1:0]       word_count
);

	tdwc_cmd_t cmd;
	tdwc_sts_t sts;

	tdwc_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tdwc_dp #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.node_index  (node_index),
		.letter      (letter),
		.child_index (child_index),
		.last_letter (last_letter),
		.word_count  (word_count)
	);

endmodule

`default_nettype wire

// ===== rtl/tdwc_ctl.sv =====
// Controller state machine for the trie dictionary word counter.
// Depends on tdwc_pkg; drives commands to tdwc_dp and owns both handshakes.
`default_nettype none

module tdwc_ctl
	import tdwc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ACTION_W-1:0] action,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire tdwc_sts_t           sts,
	output tdwc_cmd_t                cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: cmd.accept = in_valid;
			ST_WALK: cmd.issue = 1'b1;
			ST_DRAIN1, ST_DRAIN2: cmd = '0;
			ST_COMMIT: begin
				if (!sts.text_last) begin
					cmd.commit = 1'b1;
				end else if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: if (sts.clr_done) state_q <= ST_IDLE;
				ST_IDLE: if (cmd.accept && action == ACT_TEXT) state_q <= ST_WALK;
				ST_WALK: if (sts.issue_last) state_q <= ST_DRAIN1;
				ST_DRAIN1: state_q <= ST_DRAIN2;
				ST_DRAIN2: state_q <= ST_COMMIT;
				ST_COMMIT: if (cmd.commit || cmd.finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while pending");

	a_text_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && action == ACT_TEXT) |=> state_q == ST_WALK)
		else $error("text letter did not start a walk");

	a_out_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(!out_stall))
		else $error("result dropped before it was taken");

endmodule

`default_nettype wire

// ===== rtl/tdwc_dp.sv =====
// Datapath for the trie dictionary word counter: child table, word-end flags,
// active position list, walk pipeline and saturating total. Depends on tdwc_pkg.
`default_nettype none

module tdwc_dp
	import tdwc_pkg::*;
#(
	parameter int NODE_COUNT = 4096,
	parameter int MAX_WORD_LEN = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tdwc_cmd_t           cmd,
	output tdwc_sts_t                sts,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [NODE_W-1:0]   node_index,
	input  wire logic [LETTER_W-1:0] letter,
	input  wire logic [NODE_W-1:0]   child_index,
	input  wire logic                last_letter,
	output logic [COUNT_W-1:0]       word_count
);

	localparam int NODES_USED = (NODE_COUNT < NODE_LIMIT) ? NODE_COUNT : NODE_LIMIT;
	localparam int CDEPTH = NODES_USED * ALPHA_SIZE;
	localparam int AW = $clog2(CDEPTH);
	localparam int FW = $clog2(NODES_USED);
	localparam int ACT_CAP = MAX_WORD_LEN + 1;
	localparam int LW = $clog2(ACT_CAP);
	localparam int CW = $clog2(ACT_CAP + 1);

	logic [NODE_W-1:0]   child_mem [CDEPTH];
	logic                flag_mem [NODES_USED];

	logic [AW-1:0]       clr_addr_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic [LW-1:0]       rd_idx_q;
	logic [CW-1:0]       kept_q;
	logic [CW-1:0]       count_q;
	logic [NODE_W-1:0]   act_q [ACT_CAP];
	logic [COUNT_W-1:0]  total_q;
	logic [COUNT_W-1:0]  word_count_q;

	logic                valid_s1;
	logic [NODE_W-1:0]   child_s1;
	logic                valid_s2;
	logic                flag_s2;

	logic                letter_ok;
	logic                link_we;
	logic                mark_we;
	logic                keep;
	logic [AW-1:0]       link_addr;
	logic [AW-1:0]       rd_addr;

	assign letter_ok = (letter_q < LETTER_W'(ALPHA_SIZE));
	assign link_we = cmd.accept && action == ACT_LINK
		&& (32'(node_index) < NODE_COUNT) && (letter < LETTER_W'(ALPHA_SIZE))
		&& (32'(child_index) < NODE_COUNT);
	assign mark_we = cmd.accept && action == ACT_MARK && (32'(node_index) < NODE_COUNT);
	assign link_addr = AW'(node_index) * AW'(ALPHA_SIZE) + AW'(letter);
	assign rd_addr = AW'(act_q[rd_idx_q]) * AW'(ALPHA_SIZE) + AW'(letter_q);
	assign keep = valid_s1 && (child_s1 != '0);

	assign sts.clr_done = (clr_addr_q == AW'(CDEPTH - 1));
	assign sts.issue_last = ((CW'(rd_idx_q) + CW'(1)) == count_q);
	assign sts.text_last = last_q;
	assign word_count = word_count_q;

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			child_mem[clr_addr_q] <= '0;
		end else if (link_we) begin
			child_mem[link_addr] <= child_index;
		end
		if (cmd.issue && letter_ok) begin
			child_s1 <= child_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			if (32'(clr_addr_q) < NODES_USED) begin
				flag_mem[clr_addr_q[FW-1:0]] <= 1'b0;
			end
		end else if (mark_we) begin
			flag_mem[node_index[FW-1:0]] <= 1'b1;
		end
		if (keep) begin
			flag_s2 <= flag_mem[child_s1[FW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && action == ACT_TEXT) begin
			letter_q <= letter;
			last_q <= last_letter;
		end
		if (cmd.finish) begin
			word_count_q <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			rd_idx_q <= '0;
			kept_q <= '0;
			count_q <= CW'(1);
			total_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < ACT_CAP; i++) begin
				act_q[i] <= '0;
			end
		end else begin
			if (cmd.clr) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			valid_s1 <= cmd.issue && letter_ok;
			valid_s2 <= keep;
			if (cmd.accept && action == ACT_TEXT) begin
				rd_idx_q <= '0;
				kept_q <= '0;
			end
			if (cmd.issue) begin
				rd_idx_q <= rd_idx_q + LW'(1);
			end
			// keep a survivor while the list has room
			if (keep && kept_q < CW'(MAX_WORD_LEN)) begin
				act_q[kept_q[LW-1:0]] <= child_s1;
				kept_q <= kept_q + CW'(1);
			end
			if (valid_s2 && flag_s2 && total_q != '1) begin
				total_q <= total_q + COUNT_W'(1);
			end
			// root rejoins behind the survivors
			if (cmd.commit) begin
				act_q[kept_q[LW-1:0]] <= '0;
				count_q <= kept_q + CW'(1);
			end
			if (cmd.finish) begin
				act_q[0] <= '0;
				count_q <= CW'(1);
				total_q <= '0;
			end
		end
	end

	a_kept_range: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= CW'(MAX_WORD_LEN))
		else $error("survivor count beyond list capacity");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CW'(ACT_CAP)))
		else $error("active count out of range");

	a_issue_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (CW'(rd_idx_q) < count_q))
		else $error("walk read past active list");

	a_commit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.finish) |-> (!valid_s1 && !valid_s2))
		else $error("commit with walk still in flight");

endmodule

`default_nettype wire
